>>> hdl/rdb_pkg.sv
package rdb_pkg;

   typedef enum logic [1:0] {
      OP_TOGGLE     = 2'd0,
      OP_PUSH_FRONT = 2'd1,
      OP_PUSH_BACK  = 2'd2,
      OP_READ       = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  char_in;
      logic [9:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [7:0]  char_out;
      logic [10:0] length;
      logic        reversed;
      status_type  status;
   } rsp_type;

endpackage

>>> hdl/rdb_stream_if.sv
interface rdb_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/rdb_ring_mem.sv
module rdb_ring_mem #(
   parameter int DEPTH = 1024,
   parameter int AW = 10
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);
   logic [7:0] store_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hdl/reversible_deque_buffer.sv
// Channel  Direction  Payload                                 Handshake
// req_if   in         opcode, char_in, read_index             valid / ready
// rsp_if   out        char_out, length, reversed, status      valid / ready
//
// One beat in gives one beat out in the cycle after acceptance; a new beat
// is taken every cycle, set by the single write port and registered read
// port of the ring memory. Reset is synchronous and clears the pointer,
// the count, the reverse flag and the output valid; the ring contents are
// not cleared. A stalled result holds and blocks input only while it waits.
module reversible_deque_buffer #(
   parameter int DEPTH = 1024
) (
   input logic         clock,
   input logic         reset,
   rdb_stream_if.sink   req_if,
   rdb_stream_if.source rsp_if
);
   import rdb_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int MW = (CW > 10) ? CW : 10;

   req_type        req;
   logic           accept;

   logic [PW-1:0]  head_ff, head_in;
   logic [CW-1:0]  fill_ff, fill_in;
   logic           rev_ff, rev_in;
   logic           rsp_valid_ff;
   logic           read_ok_ff, read_ok_in;
   status_type     status_ff, status_in;

   logic           wr_en, rd_en;
   logic [PW-1:0]  wr_addr, rd_addr;
   logic [7:0]     rd_data;

   logic [PW-1:0]  head_dec;
   logic [PW:0]    tail_sum, read_sum;
   logic [MW-1:0]  idx_w, fill_w, pos_w;
   logic           to_front;

   assign req    = req_if.payload;
   assign accept = req_if.valid && req_if.ready;
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;

   assign head_dec = (head_ff == '0) ? PW'(DEPTH - 1) : head_ff - PW'(1);
   assign tail_sum = (PW+1)'(head_ff) + (PW+1)'(fill_ff[PW-1:0]);
   assign idx_w    = MW'(req.read_index);
   assign fill_w   = MW'(fill_ff);
   assign pos_w    = rev_ff ? (fill_w - MW'(1) - idx_w) : idx_w;
   assign read_sum = (PW+1)'(head_ff) + (PW+1)'(pos_w[PW-1:0]);
   assign rd_addr  = (read_sum >= (PW+1)'(DEPTH)) ?
                     PW'(read_sum - (PW+1)'(DEPTH)) : read_sum[PW-1:0];
   assign to_front = (req.opcode == OP_PUSH_FRONT) ^ rev_ff;

   always_comb begin
      head_in    = head_ff;
      fill_in    = fill_ff;
      rev_in     = rev_ff;
      status_in  = STATUS_OK;
      read_ok_in = 1'b0;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      wr_addr    = (tail_sum >= (PW+1)'(DEPTH)) ?
                   PW'(tail_sum - (PW+1)'(DEPTH)) : tail_sum[PW-1:0];
      case (req.opcode)
         OP_TOGGLE: begin
            rev_in = ~rev_ff;
         end
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (fill_ff >= CW'(DEPTH)) begin
               status_in = STATUS_FULL;
            end else begin
               wr_en   = accept;
               fill_in = fill_ff + CW'(1);
               if (to_front) begin
                  head_in = head_dec;
                  wr_addr = head_dec;
               end
            end
         end
         OP_READ: begin
            if (idx_w >= fill_w) begin
               status_in = STATUS_RANGE;
            end else begin
               rd_en      = accept;
               read_ok_in = 1'b1;
            end
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         fill_ff      <= '0;
         rev_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            head_ff <= head_in;
            fill_ff <= fill_in;
            rev_ff  <= rev_in;
         end
         if (req_if.ready) begin
            rsp_valid_ff <= accept;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff  <= status_in;
         read_ok_ff <= read_ok_in;
      end
   end

   rdb_ring_mem #(
      .DEPTH (DEPTH),
      .AW    (PW)
   ) u_ring_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req.char_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The state registers always hold the state left by the beat on display.
   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.payload.char_out = read_ok_ff ? rd_data : 8'd0;
   assign rsp_if.payload.length   = 11'(fill_ff);
   assign rsp_if.payload.reversed = rev_ff;
   assign rsp_if.payload.status   = status_ff;
endmodule

>>> tb/rdb_checker.sv
module rdb_checker
   import rdb_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_payload,
   output int      fail_count,
   output int      pending,
   output int      beats_checked,
   output int      full_drops,
   output int      range_misses
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [7:0]  ring_bytes [DEPTH];
   logic [9:0]  front_ptr;
   logic [10:0] fill_level;
   logic        rev_order;
   rsp_type     expected_q [$];

   task automatic report_mismatch(string what, int got, int want);
      if (fail_count < 50) begin
         $display("%0t ns: mismatch on %s, got %0d, expected %0d", $time, what, got, want);
      end
      fail_count++;
   endtask

   function automatic rsp_type apply_item(req_type r);
      rsp_type    o;
      logic [9:0] slot;
      o = '0;
      o.status = STATUS_OK;
      case (r.opcode)
         OP_TOGGLE: begin
            rev_order = ~rev_order;
         end
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (fill_level == 11'(DEPTH)) begin
               o.status = STATUS_FULL;
            end else if ((r.opcode == OP_PUSH_FRONT) != rev_order) begin
               front_ptr = front_ptr - 10'd1;
               ring_bytes[front_ptr] = r.char_in;
               fill_level++;
            end else begin
               ring_bytes[10'(front_ptr + fill_level[9:0])] = r.char_in;
               fill_level++;
            end
         end
         OP_READ: begin
            if (11'(r.read_index) >= fill_level) begin
               o.status = STATUS_RANGE;
            end else begin
               slot = rev_order ? 10'(fill_level - 11'd1 - 11'(r.read_index)) : r.read_index;
               o.char_out = ring_bytes[10'(front_ptr + slot)];
            end
         end
         default: begin
            o.status = STATUS_OK;
         end
      endcase
      o.length = fill_level;
      o.reversed = rev_order;
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         front_ptr = '0;
         fill_level = '0;
         rev_order = 1'b0;
         expected_q.delete();
         pending = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("result beat with nothing outstanding",
                               int'(rsp_payload.length), -1);
            end else begin
               want = expected_q.pop_front();
               if (rsp_payload.char_out != want.char_out)
                  report_mismatch("char_out", int'(rsp_payload.char_out), int'(want.char_out));
               if (rsp_payload.length != want.length)
                  report_mismatch("length", int'(rsp_payload.length), int'(want.length));
               if (rsp_payload.reversed != want.reversed)
                  report_mismatch("reversed", int'(rsp_payload.reversed), int'(want.reversed));
               if (rsp_payload.status != want.status)
                  report_mismatch("status", int'(rsp_payload.status), int'(want.status));
               if (want.status == STATUS_FULL) full_drops++;
               if (want.status == STATUS_RANGE) range_misses++;
               beats_checked++;
            end
         end
         if (req_valid && req_ready) begin
            expected_q.insert(expected_q.size(), apply_item(req_payload));
         end
         pending = expected_q.size();
      end
   end

endmodule

>>> tb/reversible_deque_buffer_tb.sv
module reversible_deque_buffer_tb;
   import rdb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 1024;
   localparam int LONG_HOLD = 300;

   logic clock;
   logic reset;

   rdb_stream_if #(.payload_type(req_type)) req_if ();
   rdb_stream_if #(.payload_type(rsp_type)) rsp_if ();

   int fail_count;
   int pending;
   int beats_checked;
   int full_drops;
   int range_misses;

   int stocked;
   int sent;
   bit sender_gaps;
   bit rsp_stalls;
   bit hold_request;

   reversible_deque_buffer #(.DEPTH(DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   rdb_checker #(.DEPTH(DEPTH)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_ready     (req_if.ready),
      .req_payload   (req_if.payload),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_payload   (rsp_if.payload),
      .fail_count    (fail_count),
      .pending       (pending),
      .beats_checked (beats_checked),
      .full_drops    (full_drops),
      .range_misses  (range_misses)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      rsp_if.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end else if (rsp_stalls && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic send_beat(opcode_type op, logic [7:0] ch, logic [9:0] idx);
      req_type r;
      r.opcode = op;
      r.char_in = ch;
      r.read_index = idx;
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= r;
      do @(posedge clock); while (!req_if.ready);
      if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && stocked < DEPTH) stocked++;
      sent++;
   endtask

   function automatic logic [9:0] pick_index();
      int roll;
      roll = $urandom_range(0, 9);
      if (stocked == 0 || (stocked < DEPTH && roll < 2))
         return 10'($urandom_range(stocked, DEPTH - 1));
      if (roll == 2) return 10'(stocked - 1);
      if (roll == 3) return '0;
      return 10'($urandom_range(0, stocked - 1));
   endfunction

   task automatic random_beat(int push_weight);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         send_beat(OP_TOGGLE, 8'($urandom), 10'($urandom));
      end else if (roll < 8 + push_weight) begin
         send_beat($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                   8'($urandom), 10'($urandom));
      end else begin
         send_beat(OP_READ, 8'($urandom), pick_index());
      end
   endtask

   initial begin
      req_type blank;
      int      n;
      blank = '0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = blank;
      sender_gaps = 1'b0;
      rsp_stalls = 1'b1;
      hold_request = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_beat(OP_READ, 8'h00, 10'd0);
      send_beat(OP_READ, 8'hff, 10'd1023);
      send_beat(OP_PUSH_BACK, 8'h00, 10'd0);
      send_beat(OP_PUSH_BACK, 8'hff, 10'd1023);
      send_beat(OP_PUSH_FRONT, 8'ha5, 10'd0);
      send_beat(OP_PUSH_FRONT, 8'h5a, 10'd0);
      send_beat(OP_READ, 8'h00, 10'd0);
      send_beat(OP_READ, 8'h00, 10'd1);
      send_beat(OP_READ, 8'h00, 10'd2);
      send_beat(OP_READ, 8'h00, 10'd3);
      send_beat(OP_READ, 8'h00, 10'd4);
      send_beat(OP_TOGGLE, 8'hff, 10'd1023);
      send_beat(OP_READ, 8'h00, 10'd0);
      send_beat(OP_READ, 8'h00, 10'd3);
      send_beat(OP_PUSH_FRONT, 8'h3c, 10'd0);
      send_beat(OP_PUSH_BACK, 8'hc3, 10'd0);
      send_beat(OP_READ, 8'h00, 10'd0);
      send_beat(OP_READ, 8'h00, 10'd5);
      send_beat(OP_READ, 8'h00, 10'd6);
      send_beat(OP_TOGGLE, 8'h00, 10'd0);
      send_beat(OP_READ, 8'h00, 10'd0);
      send_beat(OP_READ, 8'h00, 10'd5);

      sender_gaps = 1'b1;
      for (int i = 0; i < 450; i++) begin
         if (i == 120) hold_request = 1'b1;
         random_beat(40);
      end

      // Let the output side drain completely before the fill phase.
      req_if.valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      @(posedge clock);

      n = 0;
      while (stocked < DEPTH) begin
         sender_gaps = (n / 100) % 3 != 0;
         rsp_stalls = (n / 100) % 3 != 1;
         random_beat(70);
         n++;
      end

      sender_gaps = 1'b0;
      rsp_stalls = 1'b0;
      for (int i = 0; i < 220; i++) begin
         random_beat(30);
      end

      req_if.valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (8) @(posedge clock);

      $display("Sent %0d beats and checked %0d results, filling the ring to %0d bytes.",
               sent, beats_checked, stocked);
      $display("Saw %0d pushes dropped while full and %0d reads past the end.",
               full_drops, range_misses);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
